>>> rtl/i2cmbe_pkg.sv
// shared types, codes and helpers of the i2c master bit engine
// used by the front queue, the bus engine and the top level
package i2cmbe_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  localparam logic [1:0] REG_BIT_PHASE = 2'd0;
  localparam logic [1:0] REG_SETUP     = 2'd1;
  localparam logic [1:0] REG_ACK_SETUP = 2'd2;
  localparam logic [1:0] REG_ACK_TMO   = 2'd3;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_NONE  = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       nack;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic [7:0]  bit_phase_ticks;
    logic [7:0]  setup_ticks;
    logic [7:0]  ack_setup_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] hold_len(input logic [7:0] r);
    return (r == 8'd0) ? 8'd1 : r;
  endfunction

endpackage

>>> rtl/i2c_master_bit_engine_top.sv
// an accepted tick is written to the queue, then stepped by the engine into the result register
// one item per cycle while results are taken by the sink; the phase sequencer steps once per queued tick
// a two-entry queue decouples intake from the engine, a result register from the sink
// reset: async active low, registers back to defaults, engine idle, lines high and driven
// top level of the i2c master bit engine with timing registers
// depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_back
module i2c_master_bit_engine_top
  import i2cmbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        nack_after_read_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_missing_o
);

  cfg_t      cfg_q, cfg_d;
  tick_t     head;
  q_status_t q_status;
  logic      pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIT_PHASE: cfg_d.bit_phase_ticks = cfg_data_i[7:0];
        REG_SETUP:     cfg_d.setup_ticks     = cfg_data_i[7:0];
        REG_ACK_SETUP: cfg_d.ack_setup_ticks = cfg_data_i[7:0];
        REG_ACK_TMO:   cfg_d.ack_timeout     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_phase_ticks <= 8'd2;
      cfg_q.setup_ticks     <= 8'd4;
      cfg_q.ack_setup_ticks <= 8'd1;
      cfg_q.ack_timeout     <= 16'd250;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cmbe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_valid_i       (cmd_valid_i),
    .opcode_i          (opcode_i),
    .tx_byte_i         (tx_byte_i),
    .nack_after_read_i (nack_after_read_i),
    .sda_in_i          (sda_in_i),
    .pop_i             (pop),
    .head_o            (head),
    .status_o          (q_status)
  );

  i2cmbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_status_i    (q_status),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_o         (scl_o),
    .sda_out_o     (sda_out_o),
    .sda_drive_o   (sda_drive_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_missing_o (ack_missing_o)
  );

`ifndef SYNTHESIS
  a_ready_iff_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !q_status.full) else $error("ready disagrees with queue fill");

  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("engine stepped on an empty queue");

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o) else $error("done while busy");

  a_released_sda_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sda_drive_o) |-> sda_out_o) else $error("released sda not high");

  a_result_after_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o) else $error("step gave no result");
`endif

endmodule

>>> rtl/i2cmbe_front.sv
// front end: decodes each incoming tick and queues it for the engine
// depends on i2cmbe_pkg
module i2cmbe_front
  import i2cmbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [2:0] opcode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       nack_after_read_i,
  input  logic       sda_in_i,
  input  logic       pop_i,
  output tick_t      head_o,
  output q_status_t  status_o
);

  tick_t      mem [QueueDepth];
  tick_t      entry;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  always_comb begin
    entry.tx_byte = tx_byte_i;
    entry.nack    = nack_after_read_i;
    entry.sda     = sda_in_i;
    if (!cmd_valid_i) begin
      entry.cmd = CMD_NONE;
    end else begin
      unique case (opcode_i)
        OP_START: entry.cmd = CMD_START;
        OP_STOP:  entry.cmd = CMD_STOP;
        OP_WRITE: entry.cmd = CMD_WRITE;
        OP_READ:  entry.cmd = CMD_READ;
        OP_WAIT:  entry.cmd = CMD_WAIT;
        default:  entry.cmd = CMD_NONE;
      endcase
    end
  end

  assign in_ready_o = (count_q != 2'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= entry;
    end
  end

  assign head_o         = mem[rd_ptr_q];
  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = (count_q == 2'(QueueDepth));
  assign status_o.empty = (count_q == 2'd0);

endmodule

>>> rtl/i2cmbe_back.sv
// back end: bus phase sequencer, one queued tick per cycle while results are taken, and result register
// depends on i2cmbe_pkg
module i2cmbe_back
  import i2cmbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  q_status_t  q_status_i,
  input  tick_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       sda_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_missing_o
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_TO_A    = 4'd5;
  localparam logic [3:0] PH_TO_B    = 4'd6;
  localparam logic [3:0] PH_WR_LO   = 4'd7;
  localparam logic [3:0] PH_WR_HI   = 4'd8;
  localparam logic [3:0] PH_RD_LO   = 4'd9;
  localparam logic [3:0] PH_RD_HI   = 4'd10;
  localparam logic [3:0] PH_AK_LO   = 4'd11;
  localparam logic [3:0] PH_AK_HI   = 4'd12;
  localparam logic [3:0] PH_WA_LO   = 4'd13;
  localparam logic [3:0] PH_WA_HI   = 4'd14;
  localparam logic [3:0] PH_WA_POLL = 4'd15;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  rcv_q, rcv_d;
  logic [7:0]  tick_q, tick_d;
  logic [15:0] tmo_q, tmo_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        ack_q, ack_d;
  logic        nack_q, nack_d;
  logic        done;
  logic [7:0]  tick_dec;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_in;
  logic        step;

  logic        out_valid_q;
  logic        res_scl_q, res_sda_q, res_drv_q, res_busy_q, res_done_q, res_ack_q;
  logic [7:0]  res_rx_q;

  assign step  = q_status_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = step;

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    rcv_d    = rcv_q;
    tick_d   = tick_q;
    tmo_d    = tmo_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    drv_d    = drv_q;
    ack_d    = ack_q;
    nack_d   = nack_q;
    done     = 1'b0;
    tick_dec = tick_q;
    bit_inc  = bit_q + 4'd1;
    shift_in = {shift_q[6:0], head_i.sda};

    if (phase_q == PH_IDLE) begin
      unique case (head_i.cmd)
        CMD_START: begin
          drv_d   = 1'b1;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_ST_A;
          tick_d  = hold_len(cfg_i.setup_ticks);
        end
        CMD_STOP: begin
          drv_d   = 1'b1;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = PH_SP_A;
          tick_d  = hold_len(cfg_i.setup_ticks);
        end
        CMD_WRITE: begin
          drv_d   = 1'b1;
          scl_d   = 1'b0;
          bit_d   = 4'd0;
          sda_d   = head_i.tx_byte[7];
          shift_d = {head_i.tx_byte[6:0], 1'b0};
          phase_d = PH_WR_LO;
          tick_d  = hold_len(cfg_i.bit_phase_ticks);
        end
        CMD_READ: begin
          drv_d   = 1'b0;
          sda_d   = 1'b1;
          scl_d   = 1'b0;
          shift_d = 8'd0;
          bit_d   = 4'd0;
          nack_d  = head_i.nack;
          phase_d = PH_RD_LO;
          tick_d  = hold_len(cfg_i.bit_phase_ticks);
        end
        CMD_WAIT: begin
          drv_d   = 1'b0;
          sda_d   = 1'b1;
          ack_d   = 1'b0;
          tmo_d   = 16'd0;
          phase_d = PH_WA_LO;
          tick_d  = hold_len(cfg_i.ack_setup_ticks);
        end
        default: begin
        end
      endcase
    end else if (phase_q == PH_WA_POLL) begin
      if (!head_i.sda) begin
        scl_d   = 1'b0;
        phase_d = PH_IDLE;
        tick_d  = 8'd0;
        done    = 1'b1;
      end else if (tmo_q >= cfg_i.ack_timeout) begin
        drv_d   = 1'b1;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        phase_d = PH_TO_A;
        tick_d  = hold_len(cfg_i.setup_ticks);
      end else begin
        tmo_d = tmo_q + 16'd1;
      end
    end else begin
      if (tick_q != 8'd0) begin
        tick_dec = tick_q - 8'd1;
      end
      tick_d = tick_dec;
      if (tick_dec == 8'd0) begin
        unique case (phase_q)
          PH_ST_A: begin
            sda_d   = 1'b0;
            phase_d = PH_ST_B;
            tick_d  = hold_len(cfg_i.setup_ticks);
          end
          PH_SP_A, PH_TO_A: begin
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            phase_d = (phase_q == PH_SP_A) ? PH_SP_B : PH_TO_B;
            tick_d  = hold_len(cfg_i.setup_ticks);
          end
          PH_WR_LO, PH_RD_LO, PH_AK_LO: begin
            scl_d   = 1'b1;
            phase_d = phase_q + 4'd1;
            tick_d  = hold_len(cfg_i.bit_phase_ticks);
          end
          PH_WR_HI: begin
            scl_d = 1'b0;
            bit_d = bit_inc;
            if (bit_inc >= 4'd8) begin
              phase_d = PH_IDLE;
              tick_d  = 8'd0;
              done    = 1'b1;
            end else begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
              phase_d = PH_WR_LO;
              tick_d  = hold_len(cfg_i.bit_phase_ticks);
            end
          end
          PH_RD_HI: begin
            shift_d = shift_in;
            bit_d   = bit_inc;
            scl_d   = 1'b0;
            tick_d  = hold_len(cfg_i.bit_phase_ticks);
            if (bit_inc >= 4'd8) begin
              rcv_d   = shift_in;
              drv_d   = 1'b1;
              sda_d   = nack_q;
              phase_d = PH_AK_LO;
            end else begin
              phase_d = PH_RD_LO;
            end
          end
          PH_WA_LO: begin
            scl_d   = 1'b1;
            phase_d = PH_WA_HI;
            tick_d  = hold_len(cfg_i.ack_setup_ticks);
          end
          PH_WA_HI: begin
            phase_d = PH_WA_POLL;
            tick_d  = 8'd0;
          end
          default: begin
            // start and ack bit end with scl low, stop and timeout end as is, timeout flags a missing ack
            if (phase_q == PH_ST_B || phase_q == PH_AK_HI) begin
              scl_d = 1'b0;
            end
            if (phase_q == PH_TO_B) begin
              ack_d = 1'b1;
            end
            phase_d = PH_IDLE;
            tick_d  = 8'd0;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      rcv_q   <= 8'd0;
      tick_q  <= 8'd0;
      tmo_q   <= 16'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      ack_q   <= 1'b0;
      nack_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rcv_q   <= rcv_d;
      tick_q  <= tick_d;
      tmo_q   <= tmo_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      ack_q   <= ack_d;
      nack_q  <= nack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_scl_q  <= scl_d;
      res_sda_q  <= sda_d;
      res_drv_q  <= drv_d;
      res_busy_q <= (phase_d != PH_IDLE);
      res_done_q <= done;
      res_rx_q   <= rcv_d;
      res_ack_q  <= ack_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_o         = res_scl_q;
  assign sda_out_o     = res_sda_q;
  assign sda_drive_o   = res_drv_q;
  assign busy_res_o    = res_busy_q;
  assign done_res_o    = res_done_q;
  assign rx_byte_o     = res_rx_q;
  assign ack_missing_o = res_ack_q;

endmodule

>>> tb/tb_i2c_master_bit_engine_top.sv
// self-checking testbench of the i2c master bit engine: directed and random command
// ticks, each result compared with a tick-exact prediction of the bus lines and flags
// depends on i2cmbe_pkg and i2c_master_bit_engine_top
module tb_i2c_master_bit_engine_top;
  import i2cmbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxErrLines = 50;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_TMO_A, PH_TMO_B,
    PH_WR_LO, PH_WR_HI, PH_RD_LO, PH_RD_HI, PH_ACK_LO, PH_ACK_HI,
    PH_WA_LO, PH_WA_HI, PH_WA_POLL
  } eng_phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       nack;
    logic       sda;
  } tick_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } line_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        drv_cmd = 1'b0;
  logic [2:0]  drv_op = '0;
  logic [7:0]  drv_tx = '0;
  logic        drv_nack = 1'b0;
  logic        drv_sda = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl, sda_out, sda_drive, busy_res, done_res, ack_missing;
  logic [7:0]  rx_byte;

  i2c_master_bit_engine_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_valid_i      (drv_cmd),
    .opcode_i         (drv_op),
    .tx_byte_i        (drv_tx),
    .nack_after_read_i(drv_nack),
    .sda_in_i         (drv_sda),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .scl_o            (scl),
    .sda_out_o        (sda_out),
    .sda_drive_o      (sda_drive),
    .busy_res_o       (busy_res),
    .done_res_o       (done_res),
    .rx_byte_o        (rx_byte),
    .ack_missing_o    (ack_missing)
  );

  tick_item_t  tick_q[$];
  line_state_t want_lines_q[$];
  int unsigned err_count = 0;
  int unsigned res_idx = 0;
  int unsigned pushed = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          noise_pct = 0;
  int          hold_off = 0;
  int          stall = 0;

  // timing registers as the engine sees them
  logic [7:0]  c_bit_phase, c_setup, c_ack_setup;
  logic [15:0] c_ack_tmo;

  // engine state
  eng_phase_e  m_phase;
  logic [3:0]  m_bits;
  logic [7:0]  m_shift, m_rx, m_ticks;
  logic [15:0] m_polls;
  logic        m_scl, m_sda, m_drive, m_ack_miss, m_nack, m_done;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic log_error(string msg);
    if (err_count < MaxErrLines) $display("ERROR: %s", msg);
    err_count++;
  endtask

  function automatic int eff_ticks(logic [7:0] r);
    return (r == 8'd0) ? 1 : int'(r);
  endfunction

  function automatic void reset_engine();
    c_bit_phase = 8'd2;
    c_setup = 8'd4;
    c_ack_setup = 8'd1;
    c_ack_tmo = 16'd250;
    m_phase = PH_IDLE;
    m_bits = '0;
    m_shift = '0;
    m_rx = '0;
    m_ticks = '0;
    m_polls = '0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_drive = 1'b1;
    m_ack_miss = 1'b0;
    m_nack = 1'b0;
    m_done = 1'b0;
  endfunction

  function automatic void enter_phase(eng_phase_e ph, logic [7:0] r);
    m_phase = ph;
    m_ticks = 8'(eff_ticks(r));
  endfunction

  function automatic void finish_cmd();
    m_phase = PH_IDLE;
    m_ticks = '0;
    m_done = 1'b1;
  endfunction

  function automatic void shift_out_bit();
    m_sda = m_shift[7];
    m_shift = {m_shift[6:0], 1'b0};
  endfunction

  function automatic void step_phase(logic sda);
    case (m_phase)
      PH_START_A: begin
        m_sda = 1'b0;
        enter_phase(PH_START_B, c_setup);
      end
      PH_START_B: begin
        m_scl = 1'b0;
        finish_cmd();
      end
      PH_STOP_A: begin
        m_sda = 1'b1;
        m_scl = 1'b1;
        enter_phase(PH_STOP_B, c_setup);
      end
      PH_STOP_B: finish_cmd();
      PH_TMO_A: begin
        m_sda = 1'b1;
        m_scl = 1'b1;
        enter_phase(PH_TMO_B, c_setup);
      end
      PH_TMO_B: begin
        m_ack_miss = 1'b1;
        finish_cmd();
      end
      PH_WR_LO: begin
        m_scl = 1'b1;
        enter_phase(PH_WR_HI, c_bit_phase);
      end
      PH_WR_HI: begin
        m_scl = 1'b0;
        m_bits++;
        if (m_bits >= 4'd8) begin
          finish_cmd();
        end else begin
          shift_out_bit();
          enter_phase(PH_WR_LO, c_bit_phase);
        end
      end
      PH_RD_LO: begin
        m_scl = 1'b1;
        enter_phase(PH_RD_HI, c_bit_phase);
      end
      PH_RD_HI: begin
        m_shift = {m_shift[6:0], sda};
        m_bits++;
        m_scl = 1'b0;
        if (m_bits >= 4'd8) begin
          m_rx = m_shift;
          m_drive = 1'b1;
          m_sda = m_nack;
          enter_phase(PH_ACK_LO, c_bit_phase);
        end else begin
          enter_phase(PH_RD_LO, c_bit_phase);
        end
      end
      PH_ACK_LO: begin
        m_scl = 1'b1;
        enter_phase(PH_ACK_HI, c_bit_phase);
      end
      PH_ACK_HI: begin
        m_scl = 1'b0;
        finish_cmd();
      end
      PH_WA_LO: begin
        m_scl = 1'b1;
        enter_phase(PH_WA_HI, c_ack_setup);
      end
      PH_WA_HI: begin
        m_phase = PH_WA_POLL;
        m_ticks = '0;
      end
      default: finish_cmd();
    endcase
  endfunction

  function automatic line_state_t bus_tick(tick_item_t t);
    m_done = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        case (t.opcode)
          OP_START: begin
            m_drive = 1'b1;
            m_scl = 1'b1;
            m_sda = 1'b1;
            enter_phase(PH_START_A, c_setup);
          end
          OP_STOP: begin
            m_drive = 1'b1;
            m_scl = 1'b0;
            m_sda = 1'b0;
            enter_phase(PH_STOP_A, c_setup);
          end
          OP_WRITE: begin
            m_drive = 1'b1;
            m_scl = 1'b0;
            m_shift = t.tx_byte;
            m_bits = '0;
            shift_out_bit();
            enter_phase(PH_WR_LO, c_bit_phase);
          end
          OP_READ: begin
            m_drive = 1'b0;
            m_sda = 1'b1;
            m_scl = 1'b0;
            m_shift = '0;
            m_bits = '0;
            m_nack = t.nack;
            enter_phase(PH_RD_LO, c_bit_phase);
          end
          OP_WAIT: begin
            m_drive = 1'b0;
            m_sda = 1'b1;
            m_ack_miss = 1'b0;
            m_polls = '0;
            enter_phase(PH_WA_LO, c_ack_setup);
          end
          default: ;
        endcase
      end
    end else if (m_phase == PH_WA_POLL) begin
      if (!t.sda) begin
        m_scl = 1'b0;
        finish_cmd();
      end else if (m_polls >= c_ack_tmo) begin
        m_drive = 1'b1;
        m_scl = 1'b0;
        m_sda = 1'b0;
        enter_phase(PH_TMO_A, c_setup);
      end else begin
        m_polls++;
      end
    end else begin
      if (m_ticks != 8'd0) m_ticks--;
      if (m_ticks == 8'd0) step_phase(t.sda);
    end
    return '{m_scl, m_sda, m_drive, m_phase != PH_IDLE, m_done, m_rx, m_ack_miss};
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    tick_item_t nxt;
    logic load;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      hold_off = 0;
    end else begin
      load = 1'b0;
      nxt = '0;
      if (in_valid && in_ready) begin
        want_lines_q.push_back(bus_tick('{drv_cmd, drv_op, drv_tx, drv_nack, drv_sda}));
      end
      if (!in_valid || in_ready) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (tick_q.size() > 0) begin
          nxt = tick_q.pop_front();
          load = 1'b1;
          hold_off = pick_gap(idle_pct);
        end
        in_valid <= load;
        if (load) begin
          drv_cmd <= nxt.cmd_valid;
          drv_op <= nxt.opcode;
          drv_tx <= nxt.tx_byte;
          drv_nack <= nxt.nack;
          drv_sda <= nxt.sda;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      log_error($sformatf("result %0d %s got %0h want %0h", res_idx, name, got, want));
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    line_state_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_lines_q.size() == 0) begin
          log_error($sformatf("result %0d arrived with nothing expected", res_idx));
        end else begin
          want = want_lines_q.pop_front();
          check_field("scl", scl, want.scl);
          check_field("sda_out", sda_out, want.sda_out);
          check_field("sda_drive", sda_drive, want.sda_drive);
          check_field("busy", busy_res, want.busy);
          check_field("done", done_res, want.done);
          check_field("rx_byte", rx_byte, want.rx_byte);
          check_field("ack_missing", ack_missing, want.ack_missing);
        end
        res_idx++;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap(stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("i2c_master_bit_engine_top test failed");
      $finish;
    end
  end

  task automatic push_tick(logic c, logic [2:0] op, logic [7:0] tx, logic n, logic s);
    tick_q.push_back('{c, op, tx, n, s});
    pushed++;
  endtask

  // tick while a command runs; fill 0 or 1 fixes sda, otherwise random
  task automatic filler(int fill);
    logic s;
    s = (fill > 1) ? 1'($urandom) : 1'(fill);
    push_tick(1'($urandom_range(99) < noise_pct), 3'($urandom), 8'($urandom),
              1'($urandom), s);
  endtask

  // command item plus the ticks it keeps the engine busy
  task automatic send_cmd(logic [2:0] op, logic [7:0] tx, logic nack, int polls, int fill);
    int hb, hs, ha, pre;
    hb = eff_ticks(c_bit_phase);
    hs = eff_ticks(c_setup);
    ha = eff_ticks(c_ack_setup);
    push_tick(1'b1, op, tx, nack, 1'($urandom));
    case (op)
      OP_START, OP_STOP: pre = 2 * hs;
      OP_WRITE: pre = 16 * hb;
      OP_READ: pre = 18 * hb;
      OP_WAIT: pre = 2 * ha;
      default: pre = 0;
    endcase
    repeat (pre) filler(fill);
    if (op == OP_WAIT) begin
      if (polls > int'(c_ack_tmo)) begin
        repeat (int'(c_ack_tmo) + 1) filler(1);
        repeat (2 * hs) filler(2);
      end else begin
        repeat (polls) filler(1);
        filler(0);
      end
    end
  endtask

  function automatic int ack_polls();
    if ($urandom_range(4) == 0) return int'(c_ack_tmo) + 1;
    return $urandom_range(0, (c_ack_tmo < 16'd6) ? int'(c_ack_tmo) : 6);
  endfunction

  task automatic random_txn();
    logic [7:0] addr;
    int nbytes;
    addr = 8'($urandom);
    nbytes = $urandom_range(1, 3);
    if ($urandom_range(99) < noise_pct) begin
      repeat ($urandom_range(1, 4)) begin
        push_tick(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    send_cmd(OP_START, 8'($urandom), 1'($urandom), 0, 2);
    send_cmd(OP_WRITE, addr, 1'($urandom), 0, 2);
    send_cmd(OP_WAIT, 8'($urandom), 1'($urandom), ack_polls(), 2);
    for (int i = 0; i < nbytes; i++) begin
      if (addr[0]) begin
        send_cmd(OP_READ, 8'($urandom), (i == nbytes - 1) || ($urandom_range(3) == 0), 0, 2);
      end else begin
        send_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 0, 2);
        send_cmd(OP_WAIT, 8'($urandom), 1'($urandom), ack_polls(), 2);
      end
    end
    send_cmd(OP_STOP, 8'($urandom), 1'($urandom), 0, 2);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(3) == 0) begin
        push_tick(1'b1, OP_WAIT + 3'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                  1'($urandom));
      end else begin
        push_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic random_run(int n);
    int unsigned target;
    target = pushed + n;
    while (pushed < target) random_txn();
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || in_valid || want_lines_q.size() != 0);
  endtask

  // engine idle and every result in before the timing registers change
  task automatic settle();
    drain();
    while (m_phase != PH_IDLE) begin
      push_tick(1'b0, OP_START, 8'd0, 1'b0, 1'b0);
      drain();
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      REG_BIT_PHASE: c_bit_phase = data[7:0];
      REG_SETUP: c_setup = data[7:0];
      REG_ACK_SETUP: c_ack_setup = data[7:0];
      REG_ACK_TMO: c_ack_tmo = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] b, logic [15:0] s, logic [15:0] a, logic [15:0] t);
    settle();
    write_reg(REG_BIT_PHASE, b);
    write_reg(REG_SETUP, s);
    write_reg(REG_ACK_SETUP, a);
    write_reg(REG_ACK_TMO, t);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] with_junk(int v);
    return {8'($urandom), 8'(v)};
  endfunction

  initial begin
    reset_engine();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    stall_pct = 20;
    for (int op = int'(OP_WAIT) + 1; op < 8; op++) begin
      push_tick(1'b1, 3'(op), 8'hFF, 1'b1, 1'b1);
      push_tick(1'b0, 3'(op), 8'h00, 1'b0, 1'b0);
    end
    send_cmd(OP_START, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_WRITE, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_WRITE, 8'hFF, 1'b1, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, int'(c_ack_tmo), 2);
    noise_pct = 50;
    send_cmd(OP_WRITE, 8'hA5, 1'b0, 0, 2);
    noise_pct = 0;
    send_cmd(OP_READ, 8'h00, 1'b0, 0, 1);
    send_cmd(OP_READ, 8'hFF, 1'b1, 0, 0);
    send_cmd(OP_READ, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, int'(c_ack_tmo) + 1, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, 2, 2);
    send_cmd(OP_STOP, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, 1, 2);
    send_cmd(OP_STOP, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_START, 8'h00, 1'b0, 0, 2);
    send_cmd(OP_START, 8'h00, 1'b0, 0, 2);

    noise_pct = 6;

    set_regs(16'h0001, 16'h0001, 16'h0001, 16'h0001);
    idle_pct = 0;
    stall_pct = 0;
    random_run(60);

    set_regs(16'hFF00, 16'hFF00, 16'hFF00, 16'h0000);
    idle_pct = 30;
    stall_pct = 10;
    random_run(40);

    repeat (2) begin
      set_regs(with_junk($urandom_range(1, 3)), with_junk($urandom_range(1, 4)),
               with_junk($urandom_range(1, 3)), 16'($urandom_range(12)));
      idle_pct = $urandom_range(5, 40);
      stall_pct = $urandom_range(5, 40);
      random_run(1);
      drain();
    end

    set_regs(with_junk(3), with_junk(2), with_junk(2), 16'd2);
    idle_pct = 0;
    stall_pct = 0;
    noise_pct = 0;
    send_cmd(OP_START, 8'($urandom), 1'b0, 0, 2);
    send_cmd(OP_WRITE, 8'($urandom), 1'b0, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, 2, 2);
    send_cmd(OP_READ, 8'h00, 1'b1, 0, 2);
    send_cmd(OP_WAIT, 8'h00, 1'b0, int'(c_ack_tmo) + 1, 2);
    send_cmd(OP_STOP, 8'h00, 1'b0, 0, 2);

    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("i2c_master_bit_engine_top test passed");
    end else begin
      $display("i2c_master_bit_engine_top test failed");
    end
    $finish;
  end

endmodule
